// File: rtl/core/skt_pkg.sv
package skt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [CNT_W-1:0]            cnt_t;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

endpackage

// File: rtl/core/sorted_key_table.sv
// A request walks the key memory: an insert from the last key down, shifting keys up,
// a delete or lookup from the first key up; lookup hits and inserts stop early; clear and
// insert into a full table skip the walk. A result beat still waiting holds the next report.
// Requests are taken one at a time, each held by the walk through the key memory, one read
// and one write per cycle.
// Reset (rst, synchronous): table empty, no result pending; key memory is not cleared.
module sorted_key_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              req_type,
  input  skt_pkg::key_t           key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic                    found,
  output skt_pkg::key_t           found_key,
  output skt_pkg::cnt_t           entry_count,
  output logic                    is_full
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INS    = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  skt_pkg::key_t mem [skt_pkg::CAPACITY];
  skt_pkg::key_t rdata;

  logic [1:0]    state, state_next;
  logic [1:0]    req, req_next;
  skt_pkg::key_t key_r, key_next;
  skt_pkg::cnt_t count, count_next;
  skt_pkg::idx_t rd_ptr, rd_ptr_next;
  skt_pkg::cnt_t rd_left, rd_left_next;
  logic          pend, pend_next;
  skt_pkg::idx_t pend_idx, pend_idx_next;
  logic          hit, hit_next;
  logic [1:0]    res_status, res_status_next;

  logic          we;
  skt_pkg::idx_t wa;
  skt_pkg::key_t wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_ptr];
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    req_next        = req;
    key_next        = key_r;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    rd_left_next    = rd_left;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    hit_next        = hit;
    res_status_next = res_status;
    we              = 1'b0;
    wa              = pend_idx + 1'b1;
    wd              = rdata;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next        = req_type;
          key_next        = key;
          hit_next        = 1'b0;
          res_status_next = skt_pkg::ST_DONE;
          rd_left_next    = count;
          unique case (req_type) inside
            skt_pkg::REQ_INSERT: begin
              rd_ptr_next = skt_pkg::IDX_W'(count - 1'b1);
              if (count == skt_pkg::CNT_W'(skt_pkg::CAPACITY)) begin
                res_status_next = skt_pkg::ST_FULL;
                state_next      = S_REPORT;
              end else begin
                state_next = S_INS;
              end
            end
            skt_pkg::REQ_DELETE, skt_pkg::REQ_LOOKUP: begin
              rd_ptr_next = '0;
              state_next  = S_SCAN;
            end
            default: begin
              count_next = '0;
              state_next = S_REPORT;
            end
          endcase
        end
      end

      S_INS: begin
        if (rd_left != '0) begin
          pend_next     = 1'b1;
          pend_idx_next = rd_ptr;
          rd_ptr_next   = rd_ptr - 1'b1;
          rd_left_next  = rd_left - 1'b1;
        end
        if (pend) begin
          we = 1'b1;
          wa = pend_idx + 1'b1;
          if (rdata >= key_r) begin
            wd = rdata;
          end else begin
            wd         = key_r;
            pend_next  = 1'b0;
            count_next = count + 1'b1;
            state_next = S_REPORT;
          end
        end else if (rd_left == '0) begin
          we         = 1'b1;
          wa         = '0;
          wd         = key_r;
          count_next = count + 1'b1;
          state_next = S_REPORT;
        end
      end

      S_SCAN: begin
        if (rd_left != '0) begin
          pend_next     = 1'b1;
          pend_idx_next = rd_ptr;
          rd_ptr_next   = rd_ptr + 1'b1;
          rd_left_next  = rd_left - 1'b1;
        end
        if (pend) begin
          if (hit) begin
            we = 1'b1;
            wa = pend_idx - 1'b1;
            wd = rdata;
          end else if (rdata == key_r) begin
            hit_next = 1'b1;
            if (req == skt_pkg::REQ_LOOKUP) begin
              pend_next  = 1'b0;
              state_next = S_REPORT;
            end
          end
        end else if (rd_left == '0) begin
          if (hit) begin
            count_next = count - 1'b1;
          end else begin
            res_status_next = skt_pkg::ST_ABSENT;
          end
          state_next = S_REPORT;
        end
      end

      S_REPORT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (state == S_REPORT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    key_r      <= key_next;
    rd_ptr     <= rd_ptr_next;
    rd_left    <= rd_left_next;
    pend_idx   <= pend_idx_next;
    hit        <= hit_next;
    res_status <= res_status_next;
    if (state == S_REPORT && (!out_valid || out_ready)) begin
      status      <= res_status;
      found       <= hit;
      found_key   <= (hit && req == skt_pkg::REQ_LOOKUP) ? key_r : '0;
      entry_count <= count;
      is_full     <= (count == skt_pkg::CNT_W'(skt_pkg::CAPACITY));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
    else $error("stored count above capacity");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_INS || state == S_SCAN))
    else $error("read pending outside walk");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == skt_pkg::ST_FULL) |-> is_full)
    else $error("insert dropped while table not full");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == skt_pkg::ST_DONE))
    else $error("found beat with bad status");

  a_key_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_key != '0) |-> found)
    else $error("found_key set without match");

endmodule

// File: tb/tb_sorted_key_table.sv
module tb_sorted_key_table;

  localparam skt_pkg::key_t KEY_MIN =
    skt_pkg::key_t'({1'b1, {(skt_pkg::KEY_WIDTH-1){1'b0}}});
  localparam skt_pkg::key_t KEY_MAX =
    skt_pkg::key_t'({1'b0, {(skt_pkg::KEY_WIDTH-1){1'b1}}});

  typedef struct packed {
    logic [1:0]    status;
    logic          found;
    skt_pkg::key_t found_key;
    skt_pkg::cnt_t entry_count;
    logic          is_full;
  } table_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    req_type = skt_pkg::REQ_INSERT;
  skt_pkg::key_t key = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    status;
  logic          found;
  skt_pkg::key_t found_key;
  skt_pkg::cnt_t entry_count;
  logic          is_full;

  int            send_idle_pct = 23;
  int            recv_idle_pct = 82;
  int            fail_count = 0;
  int            result_index = 0;
  table_result_t expected_results[$];

  skt_pkg::key_t table_keys[skt_pkg::CAPACITY];
  int            stored_total = 0;

  sorted_key_table dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found      (found),
    .found_key  (found_key),
    .entry_count(entry_count),
    .is_full    (is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Updates the table image and returns what the request should report.
  function automatic table_result_t apply_request(input logic [1:0] op,
                                                  input skt_pkg::key_t k);
    table_result_t r;
    int pos;
    r = '0;
    r.status = skt_pkg::ST_DONE;
    pos = 0;
    case (op)
      skt_pkg::REQ_INSERT: begin
        if (stored_total >= skt_pkg::CAPACITY) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          while (pos < stored_total && table_keys[pos] < k) pos++;
          for (int i = stored_total; i > pos; i--) table_keys[i] = table_keys[i-1];
          table_keys[pos] = k;
          stored_total++;
        end
      end
      skt_pkg::REQ_DELETE: begin
        while (pos < stored_total && table_keys[pos] != k) pos++;
        if (pos < stored_total) begin
          r.found = 1'b1;
          for (int i = pos; i + 1 < stored_total; i++) table_keys[i] = table_keys[i+1];
          stored_total--;
        end else begin
          r.status = skt_pkg::ST_ABSENT;
        end
      end
      skt_pkg::REQ_LOOKUP: begin
        while (pos < stored_total && table_keys[pos] < k) pos++;
        if (pos < stored_total && table_keys[pos] == k) begin
          r.found = 1'b1;
          r.found_key = table_keys[pos];
        end else begin
          r.status = skt_pkg::ST_ABSENT;
        end
      end
      default: begin
        stored_total = 0;
      end
    endcase
    r.entry_count = skt_pkg::cnt_t'(stored_total);
    r.is_full = (stored_total >= skt_pkg::CAPACITY);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 50) $display("mismatch: %s", what);
  endtask

  task automatic send_request(input logic [1:0] op, input skt_pkg::key_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(apply_request(op, k));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  result_index));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || found !== want.found ||
            found_key !== want.found_key || entry_count !== want.entry_count ||
            is_full !== want.is_full)
          report_mismatch($sformatf(
            "beat %0d got st=%0d f=%0b k=%0d n=%0d full=%0b want st=%0d f=%0b k=%0d n=%0d full=%0b",
            result_index, status, found, found_key, entry_count, is_full,
            want.status, want.found, want.found_key, want.entry_count, want.is_full));
      end
      result_index++;
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_empty_table();
    send_request(skt_pkg::REQ_LOOKUP, '0);
    send_request(skt_pkg::REQ_DELETE, KEY_MIN);
    send_request(skt_pkg::REQ_CLEAR, KEY_MAX);
  endtask

  task automatic test_order_and_duplicates();
    send_request(skt_pkg::REQ_INSERT, KEY_MAX);
    send_request(skt_pkg::REQ_INSERT, KEY_MIN);
    send_request(skt_pkg::REQ_INSERT, '0);
    send_request(skt_pkg::REQ_INSERT, skt_pkg::key_t'(-1));
    send_request(skt_pkg::REQ_INSERT, '0);
    send_request(skt_pkg::REQ_LOOKUP, KEY_MIN);
    send_request(skt_pkg::REQ_LOOKUP, KEY_MAX);
    send_request(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(-1));
    send_request(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(5));
    send_request(skt_pkg::REQ_DELETE, '0);
    send_request(skt_pkg::REQ_LOOKUP, '0);
    send_request(skt_pkg::REQ_DELETE, skt_pkg::key_t'(7));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < skt_pkg::CAPACITY; i++)
      send_request(skt_pkg::REQ_INSERT, skt_pkg::key_t'(skt_pkg::CAPACITY / 2 - i));
    send_request(skt_pkg::REQ_INSERT, KEY_MAX);
    send_request(skt_pkg::REQ_LOOKUP, skt_pkg::key_t'(skt_pkg::CAPACITY / 2));
    send_request(skt_pkg::REQ_DELETE, skt_pkg::key_t'(1 - skt_pkg::CAPACITY / 2));
    send_request(skt_pkg::REQ_INSERT, KEY_MIN);
    send_request(skt_pkg::REQ_CLEAR, '0);
  endtask

  function automatic skt_pkg::key_t choose_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30 && stored_total > 0)
      return table_keys[$urandom_range(stored_total - 1)];
    if (pick < 55)
      return skt_pkg::key_t'(int'($urandom_range(16)) - 8);
    if (pick < 65) begin
      case ($urandom_range(3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return skt_pkg::key_t'(-1);
        default: return '0;
      endcase
    end
    return skt_pkg::key_t'($urandom);
  endfunction

  task automatic test_random_traffic(input int count, input int ins_pct, input int del_pct);
    int unsigned pick;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < ins_pct) op = skt_pkg::REQ_INSERT;
      else if (pick < ins_pct + del_pct) op = skt_pkg::REQ_DELETE;
      else if (pick < 97) op = skt_pkg::REQ_LOOKUP;
      else op = skt_pkg::REQ_CLEAR;
      send_request(op, choose_key());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_order_and_duplicates();
    test_full_table();
    test_random_traffic(400, 45, 25);
    wait_for_results();
    send_idle_pct = 82;
    recv_idle_pct = 23;
    test_random_traffic(400, 30, 40);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400, 55, 20);
    wait_for_results();
    repeat (skt_pkg::CAPACITY + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
